// ===== rtl/mto_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix traversal order engine package
// Shared constants, codes and types of the traversal order engine.
// ----------------------------------------------------------------------------
package mto_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLUMNS = 8;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int DIM_W       = 4;
  localparam int POS_W       = 3;
  localparam int DATA_W      = 32;
  localparam int MODE_W      = 2;
  localparam int IDX_W       = 2;
  localparam int OUT_TDATA_W = 40;

  localparam logic [MODE_W-1:0] MODE_SNAKE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DIAG   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SPIRAL = 2'd2;

  localparam logic [IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
  localparam logic [IDX_W-1:0] REG_ORDER_MODE   = 2'd2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_SHOW
  } state_t;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_t;

  typedef struct packed {
    logic start;
    logic advance;
  } walk_ctl_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } walk_sts_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > max_v) begin
      res = max_v;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== rtl/mto_store.sv =====
// ----------------------------------------------------------------------------
// Matrix element store
// Single write port, single registered read port holding the loaded elements.
// ----------------------------------------------------------------------------
module mto_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [mto_pkg::ADDR_W-1:0] wr_addr,
  input  logic [mto_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [mto_pkg::ADDR_W-1:0] rd_addr,
  output logic [mto_pkg::DATA_W-1:0] rd_data
);
  import mto_pkg::*;

  logic [DATA_W-1:0] mem [STORE_DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/mto_walk.sv =====
// ----------------------------------------------------------------------------
// Traversal coordinate walker
// Steps a row and column position through snake, anti-diagonal or spiral order.
// ----------------------------------------------------------------------------
module mto_walk (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mto_pkg::walk_ctl_t         ctl,
  input  logic [mto_pkg::MODE_W-1:0] mode,
  input  logic [mto_pkg::POS_W-1:0]  rows_m1,
  input  logic [mto_pkg::POS_W-1:0]  cols_m1,
  input  logic [mto_pkg::ADDR_W-1:0] last_idx,
  output mto_pkg::walk_sts_t         sts
);
  import mto_pkg::*;

  logic [POS_W-1:0]  row_r, row_nxt;
  logic [POS_W-1:0]  col_r, col_nxt;
  logic [POS_W-1:0]  top_r, top_nxt;
  logic [POS_W-1:0]  bottom_r, bottom_nxt;
  logic [POS_W-1:0]  left_r, left_nxt;
  logic [POS_W-1:0]  right_r, right_nxt;
  dir_t              dir_r, dir_nxt;
  logic [ADDR_W-1:0] step_r, step_nxt;
  logic [POS_W:0]    diag_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      top_r    <= '0;
      bottom_r <= '0;
      left_r   <= '0;
      right_r  <= '0;
      dir_r    <= DIR_RIGHT;
      step_r   <= '0;
    end else begin
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      top_r    <= top_nxt;
      bottom_r <= bottom_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      dir_r    <= dir_nxt;
      step_r   <= step_nxt;
    end
  end

  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    top_nxt    = top_r;
    bottom_nxt = bottom_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    dir_nxt    = dir_r;
    step_nxt   = step_r;
    diag_sum   = {1'b0, row_r} + {1'b0, col_r} + (POS_W+1)'(1);
    if (ctl.start) begin
      row_nxt    = '0;
      col_nxt    = '0;
      top_nxt    = '0;
      bottom_nxt = rows_m1;
      left_nxt   = '0;
      right_nxt  = cols_m1;
      dir_nxt    = DIR_RIGHT;
      step_nxt   = '0;
    end else if (ctl.advance) begin
      step_nxt = step_r + ADDR_W'(1);
      unique case (mode)
        MODE_SNAKE: begin
          if (!row_r[0]) begin
            if (col_r == cols_m1) begin
              row_nxt = row_r + POS_W'(1);
            end else begin
              col_nxt = col_r + POS_W'(1);
            end
          end else begin
            if (col_r == '0) begin
              row_nxt = row_r + POS_W'(1);
            end else begin
              col_nxt = col_r - POS_W'(1);
            end
          end
        end
        MODE_DIAG: begin
          if (row_r < cols_m1 && col_r != '0) begin
            row_nxt = row_r + POS_W'(1);
            col_nxt = col_r - POS_W'(1);
          end else if (diag_sum <= {1'b0, cols_m1}) begin
            row_nxt = '0;
            col_nxt = diag_sum[POS_W-1:0];
          end else begin
            row_nxt = POS_W'(diag_sum - {1'b0, cols_m1});
            col_nxt = cols_m1;
          end
        end
        default: begin
          unique case (dir_r)
            DIR_RIGHT: begin
              if (col_r < right_r) begin
                col_nxt = col_r + POS_W'(1);
              end else begin
                top_nxt = top_r + POS_W'(1);
                dir_nxt = DIR_DOWN;
                row_nxt = row_r + POS_W'(1);
              end
            end
            DIR_DOWN: begin
              if (row_r < bottom_r) begin
                row_nxt = row_r + POS_W'(1);
              end else begin
                right_nxt = right_r - POS_W'(1);
                dir_nxt   = DIR_LEFT;
                col_nxt   = col_r - POS_W'(1);
              end
            end
            DIR_LEFT: begin
              if (col_r > left_r) begin
                col_nxt = col_r - POS_W'(1);
              end else begin
                bottom_nxt = bottom_r - POS_W'(1);
                dir_nxt    = DIR_UP;
                row_nxt    = row_r - POS_W'(1);
              end
            end
            default: begin
              if (row_r > top_r) begin
                row_nxt = row_r - POS_W'(1);
              end else begin
                left_nxt = left_r + POS_W'(1);
                dir_nxt  = DIR_RIGHT;
                col_nxt  = col_r + POS_W'(1);
              end
            end
          endcase
        end
      endcase
    end
  end

  assign sts.row  = row_r;
  assign sts.col  = col_r;
  assign sts.last = (step_r == last_idx);

endmodule

// ===== rtl/matrix_traversal_order_engine_top.sv =====
// ----------------------------------------------------------------------------
// Matrix traversal order engine
// Loads a matrix row by row and replays it in snake, anti-diagonal or
// clockwise spiral order.
// ----------------------------------------------------------------------------
// The input stream carries one signed 32-bit element per transaction in
// row-major order, and in_tready stays high while loading. The transaction
// that completes the matrix starts a replay, and in_tready stays low until
// the last element of that replay has been taken on the output stream.
// Each output element passes through the read state, which reads the
// element store at the walker position, and then the show state, which
// presents it; the walker steps when the element is taken.
// A receiver stall simply holds the presented element until out_tready.
// Diagonal order on a non-square matrix, and the unused mode code, complete
// the load without any output.
// The configuration port writes row_count, column_count and order_mode and
// must only be used while the engine is idle. Reset restores an 8 by 8 matrix
// in snake order and restarts loading at the first element; the element store
// itself is not cleared.
// ----------------------------------------------------------------------------
module matrix_traversal_order_engine_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mto_pkg::DATA_W-1:0]      in_tdata,   // [31:0] element_value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mto_pkg::OUT_TDATA_W-1:0] out_tdata,  // [31:0] out_value,
                                                      // [34:32] out_row,
                                                      // [37:35] out_column
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [mto_pkg::IDX_W-1:0]       cfg_index,
  input  logic [mto_pkg::DIM_W-1:0]       cfg_wdata
);
  import mto_pkg::*;

  state_t            state_r, state_nxt;
  logic [DIM_W-1:0]  row_count_r;
  logic [DIM_W-1:0]  column_count_r;
  logic [MODE_W-1:0] order_mode_r;
  logic [CNT_W-1:0]  load_count_r, load_count_nxt;

  logic [DIM_W-1:0]  rows;
  logic [DIM_W-1:0]  cols;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  load_pos;
  logic [CNT_W-1:0]  load_cnt;
  logic              in_fire;
  logic              out_fire;
  logic              replay_on;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;
  walk_ctl_t         walk_ctl;
  walk_sts_t         walk_sts;

  assign rows  = clamp_dim(row_count_r, DIM_W'(MAX_ROWS));
  assign cols  = clamp_dim(column_count_r, DIM_W'(MAX_COLUMNS));
  assign total = CNT_W'(rows) * CNT_W'(cols);

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign load_pos = (load_count_r >= total) ? '0 : load_count_r;
  assign load_cnt = load_pos + CNT_W'(1);

  assign replay_on = (order_mode_r == MODE_SNAKE) || (order_mode_r == MODE_SPIRAL) ||
                     ((order_mode_r == MODE_DIAG) && (rows == cols));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= DIM_W'(MAX_ROWS);
      column_count_r <= DIM_W'(MAX_COLUMNS);
      order_mode_r   <= MODE_SNAKE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count_r    <= cfg_wdata;
        REG_COLUMN_COUNT: column_count_r <= cfg_wdata;
        REG_ORDER_MODE:   order_mode_r   <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      load_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      load_count_r <= load_count_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    load_count_nxt   = load_count_r;
    walk_ctl.start   = 1'b0;
    walk_ctl.advance = 1'b0;
    in_tready        = 1'b0;
    out_tvalid       = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_fire) begin
          if (load_cnt < total) begin
            load_count_nxt = load_cnt;
          end else begin
            load_count_nxt = '0;
            if (replay_on) begin
              walk_ctl.start = 1'b1;
              state_nxt      = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        out_tvalid = 1'b1;
        if (out_fire) begin
          if (walk_sts.last) begin
            state_nxt = ST_LOAD;
          end else begin
            walk_ctl.advance = 1'b1;
            state_nxt        = ST_READ;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign rd_addr = ADDR_W'(ADDR_W'(walk_sts.row) * ADDR_W'(cols)) + ADDR_W'(walk_sts.col);

  mto_store u_store (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (load_pos[ADDR_W-1:0]),
    .wr_data (in_tdata),
    .rd_en   (state_r == ST_READ),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mto_walk u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (walk_ctl),
    .mode     (order_mode_r),
    .rows_m1  (POS_W'(rows - DIM_W'(1))),
    .cols_m1  (POS_W'(cols - DIM_W'(1))),
    .last_idx (ADDR_W'(total - CNT_W'(1))),
    .sts      (walk_sts)
  );

  assign out_tdata = {2'b00, walk_sts.col, walk_sts.row, rd_data};
  assign out_tlast = walk_sts.last;

endmodule

// ===== rtl/mto_checker.sv =====
// ----------------------------------------------------------------------------
// Traversal engine port checker
// Port-level assertions on the traversal engine, bound to the top level.
// ----------------------------------------------------------------------------
module mto_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mto_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a replay is in progress");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("engine not idle after reset");

  a_last_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("engine not back to loading after the final transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled output transaction changed");

  a_in_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> (!in_tready && !out_tvalid))
    else $error("replay step did not take a read cycle");

endmodule

bind matrix_traversal_order_engine_top mto_checker u_mto_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
